// ===== rtl/core/ptwa_pkg.sv =====
package ptwa_pkg;

  localparam int SLOTS     = 64;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int HOST_BITS = 8;
  localparam int HOST_W    = 8;
  localparam int KEY_W     = 32;
  localparam int TIME_W    = 32;
  localparam int EXP_W     = 16;
  localparam int CNT_W     = SLOT_BITS + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_LOOK,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    RES_ADDED,
    RES_FULL,
    RES_HIT,
    RES_EXPIRED,
    RES_MISS
  } res_e;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_LOOK = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [HOST_BITS-1:0] host;
    logic [TIME_W-1:0]    stamp;
  } row_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic advance;
    logic write_slot;
    logic free_slot;
    logic res_set;
    res_e res;
  } cmd_t;

  typedef struct packed {
    logic free_here;
    logic cnt_last;
    logic issue_done;
    logic chk_valid;
    logic chk_match;
    logic chk_stale;
    logic chk_last;
  } status_t;

endpackage

// ===== rtl/core/ptwa_ctrl.sv =====
module ptwa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              req_type_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ptwa_pkg::status_t status_i,
  output ptwa_pkg::cmd_t    cmd_o
);
  import ptwa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.res   = RES_MISS;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (req_type_i == REQ_LOOK) ? ST_LOOK : ST_ADD;
        end
      end
      ST_ADD: begin
        if (status_i.free_here) begin
          cmd_o.write_slot = 1'b1;
          cmd_o.res_set    = 1'b1;
          cmd_o.res        = RES_ADDED;
          state_d          = ST_DONE;
        end else if (status_i.cnt_last) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res     = RES_FULL;
          state_d       = ST_DONE;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_LOOK: begin
        // One slot is read per cycle while the previous slot's row is checked.
        if (status_i.chk_match) begin
          cmd_o.res_set = 1'b1;
          if (status_i.chk_stale) begin
            cmd_o.free_slot = 1'b1;
            cmd_o.res       = RES_EXPIRED;
          end else begin
            cmd_o.res = RES_HIT;
          end
          state_d = ST_DONE;
        end else if (status_i.chk_valid && status_i.chk_last) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res     = RES_MISS;
          state_d       = ST_DONE;
        end else if (!status_i.issue_done) begin
          cmd_o.issue = 1'b1;
        end
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = (req_type_i == REQ_LOOK) ? ST_LOOK : ST_ADD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ptwa_dpath.sv =====
module ptwa_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [ptwa_pkg::KEY_W-1:0]       client_key_i,
  input  logic [ptwa_pkg::HOST_W-1:0]      host_in_i,
  input  logic [ptwa_pkg::TIME_W-1:0]      now_seconds_i,
  input  logic                             cfg_write_i,
  input  logic [ptwa_pkg::EXP_W-1:0]       cfg_data_i,
  input  ptwa_pkg::cmd_t                   cmd_i,
  output ptwa_pkg::status_t                status_o,
  output logic                             found_o,
  output logic [ptwa_pkg::HOST_W-1:0]      host_out_o,
  output logic                             expired_o,
  output logic                             added_o,
  output logic                             table_full_o
);
  import ptwa_pkg::*;

  logic [EXP_W-1:0]     expiry_q;
  logic [SLOTS-1:0]     valid_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [SLOT_BITS-1:0] slot;
  logic [KEY_W-1:0]     key_q;
  logic [HOST_BITS-1:0] host_q;
  logic [TIME_W-1:0]    now_q;
  row_t                 mem_q [SLOTS];
  row_t                 rd_q;
  logic                 pend_q;
  logic                 vld_q;
  logic [SLOT_BITS-1:0] idx_q;
  logic [TIME_W-1:0]    age;
  logic                 found_q, expired_q, added_q, full_q;
  logic [HOST_BITS-1:0] hout_q;

  assign slot = cnt_q[SLOT_BITS-1:0];
  assign age  = now_q - rd_q.stamp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= '0;
    end else if (cfg_write_i) begin
      expiry_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q  <= '0;
        pend_q <= 1'b0;
      end else if (cmd_i.issue) begin
        cnt_q  <= cnt_q + CNT_W'(1);
        pend_q <= 1'b1;
      end else if (cmd_i.advance) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.write_slot) begin
        valid_q[slot] <= 1'b1;
      end else if (cmd_i.free_slot) begin
        valid_q[idx_q] <= 1'b0;
      end
    end
  end

  // Request capture and the check stage that trails the table read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= client_key_i;
      host_q <= host_in_i[HOST_BITS-1:0];
      now_q  <= now_seconds_i;
    end
    if (cmd_i.issue) begin
      idx_q <= slot;
      vld_q <= valid_q[slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_slot) begin
      mem_q[slot] <= '{key: key_q, host: host_q, stamp: now_q};
    end
    if (cmd_i.issue) begin
      rd_q <= mem_q[slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      found_q   <= (cmd_i.res == RES_HIT);
      expired_q <= (cmd_i.res == RES_EXPIRED);
      added_q   <= (cmd_i.res == RES_ADDED);
      full_q    <= (cmd_i.res == RES_FULL);
      hout_q    <= (cmd_i.res == RES_HIT) ? rd_q.host : '0;
    end
  end

  always_comb begin
    status_o.free_here  = !valid_q[slot];
    status_o.cnt_last   = (cnt_q == CNT_W'(SLOTS - 1));
    status_o.issue_done = (cnt_q == CNT_W'(SLOTS));
    status_o.chk_valid  = pend_q;
    status_o.chk_match  = pend_q && vld_q && (rd_q.key == key_q);
    status_o.chk_stale  = (expiry_q != '0) && (age > TIME_W'(expiry_q));
    status_o.chk_last   = (idx_q == SLOT_BITS'(SLOTS - 1));
  end

  assign found_o      = found_q;
  assign expired_o    = expired_q;
  assign added_o      = added_q;
  assign table_full_o = full_q;
  assign host_out_o   = HOST_W'(hout_q);

endmodule

// ===== rtl/core/persistence_table_with_aging_unit.sv =====
// An add probes the slots in order for a free one; a lookup reads the table slot by
// slot, and the key check on each row read follows in the next cycle. One request
// is handled at a time: a new request is only taken once the previous result has
// been transferred.
// Reset clears all slot valid flags at once and sets the expiry limit to zero;
// the table rows themselves are not cleared.
module persistence_table_with_aging_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [ptwa_pkg::KEY_W-1:0]  client_key_i,
  input  logic [ptwa_pkg::HOST_W-1:0] host_in_i,
  input  logic [ptwa_pkg::TIME_W-1:0] now_seconds_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [ptwa_pkg::HOST_W-1:0] host_out_o,
  output logic                        expired_o,
  output logic                        added_o,
  output logic                        table_full_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ptwa_pkg::EXP_W-1:0]  cfg_data_i
);
  import ptwa_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  ptwa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (req_type_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ptwa_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .client_key_i  (client_key_i),
    .host_in_i     (host_in_i),
    .now_seconds_i (now_seconds_i),
    .cfg_write_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .found_o       (found_o),
    .host_out_o    (host_out_o),
    .expired_o     (expired_o),
    .added_o       (added_o),
    .table_full_o  (table_full_o)
  );

endmodule

// ===== rtl/core/ptwa_checker.sv =====
module ptwa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        found_o,
  input logic [ptwa_pkg::HOST_W-1:0] host_out_o,
  input logic                        expired_o,
  input logic                        added_o,
  input logic                        table_full_o
);

  // A pending result stays on the port until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before transfer");

  // Every result carries at most one outcome flag.
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({found_o, expired_o, added_o, table_full_o}))
    else $error("more than one outcome flag set");

  a_host_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> host_out_o == '0)
    else $error("host reported without a hit");

  // A new request is only taken once the previous result leaves.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && out_valid_o |-> out_ready_i)
    else $error("request taken while a result is stalled");

endmodule

bind persistence_table_with_aging_unit ptwa_checker u_ptwa_checker (.*);

// ===== tb/persistence_table_with_aging_unit_tb.sv =====
module persistence_table_with_aging_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptwa_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SCAN_CYCLES = 70;
  localparam int KEY_POOL    = 20;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 150;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic              found;
    logic [HOST_W-1:0] host;
    logic              expired;
    logic              added;
    logic              full;
  } reply_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic              req;
    logic [KEY_W-1:0]  key;
    logic [HOST_W-1:0] host;
    logic [TIME_W-1:0] stamp;
    logic [EXP_W-1:0]  limit;
    logic              typed;
    reply_t            want;
  } dir_row_t;

  localparam reply_t R_MISS    = '0;
  localparam reply_t R_ADDED   = '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0};
  localparam reply_t R_EXPIRED = '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0};

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_REQ, REQ_LOOK, 32'h0000_0000, 8'h00, 32'h0000_0000, 16'h0, 1'b1, R_MISS},
    '{ROW_REQ, REQ_ADD,  32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 16'h0, 1'b1, R_ADDED},
    '{ROW_REQ, REQ_LOOK, 32'hFFFF_FFFF, 8'h00, 32'h0000_0000, 16'h0, 1'b1,
      '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0}},
    '{ROW_REQ, REQ_ADD,  32'h0000_0000, 8'h00, 32'h0000_0000, 16'h0, 1'b1, R_ADDED},
    '{ROW_REQ, REQ_LOOK, 32'h0000_0000, 8'hFF, 32'h1234_5678, 16'h0, 1'b1,
      '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{ROW_REQ, REQ_ADD,  32'h0A00_0001, 8'h12, 32'd100,       16'h0, 1'b1, R_ADDED},
    // Same key again: the table keeps both copies.
    '{ROW_REQ, REQ_ADD,  32'h0A00_0001, 8'h34, 32'd200,       16'h0, 1'b1, R_ADDED},
    '{ROW_REQ, REQ_LOOK, 32'h0A00_0001, 8'h00, 32'hFFFF_FFFF, 16'h0, 1'b1,
      '{1'b1, 8'h12, 1'b0, 1'b0, 1'b0}},
    '{ROW_CFG, REQ_ADD,  32'h0,         8'h00, 32'h0,         16'd10, 1'b0, R_MISS},
    // Age equal to the limit is still live; one more second makes it stale.
    '{ROW_REQ, REQ_LOOK, 32'h0A00_0001, 8'h00, 32'd110,       16'h0, 1'b1,
      '{1'b1, 8'h12, 1'b0, 1'b0, 1'b0}},
    '{ROW_REQ, REQ_LOOK, 32'h0A00_0001, 8'h00, 32'd111,       16'h0, 1'b1, R_EXPIRED},
    '{ROW_REQ, REQ_LOOK, 32'h0A00_0001, 8'h00, 32'd111,       16'h0, 1'b0, R_MISS},
    '{ROW_REQ, REQ_LOOK, 32'h0A00_0001, 8'h00, 32'd112,       16'h0, 1'b0, R_MISS},
    '{ROW_REQ, REQ_ADD,  32'h0A00_0001, 8'h56, 32'd300,       16'h0, 1'b0, R_MISS},
    '{ROW_REQ, REQ_ADD,  32'h5A5A_5A5A, 8'hA5, 32'd300,       16'h0, 1'b0, R_MISS},
    '{ROW_CFG, REQ_ADD,  32'h0,         8'h00, 32'h0,         16'hFFFF, 1'b0, R_MISS},
    // Lookup times just past zero against a stamp at the top of the range, so the age wraps through zero.
    '{ROW_REQ, REQ_LOOK, 32'hFFFF_FFFF, 8'h00, 32'h0000_FFFE, 16'h0, 1'b0, R_MISS},
    '{ROW_REQ, REQ_LOOK, 32'hFFFF_FFFF, 8'h00, 32'h0000_FFFF, 16'h0, 1'b0, R_MISS},
    '{ROW_REQ, REQ_LOOK, 32'h0000_0000, 8'h00, 32'h0000_FFFF, 16'h0, 1'b0, R_MISS},
    '{ROW_CFG, REQ_ADD,  32'h0,         8'h00, 32'h0,         16'h0, 1'b0, R_MISS},
    '{ROW_REQ, REQ_LOOK, 32'h0A00_0001, 8'h00, 32'h0000_0000, 16'h0, 1'b0, R_MISS},
    '{ROW_REQ, REQ_LOOK, 32'h5A5A_5A5A, 8'h00, 32'h8000_0000, 16'h0, 1'b0, R_MISS},
    '{ROW_REQ, REQ_ADD,  32'hAAAA_AAAA, 8'h55, 32'h5555_5555, 16'h0, 1'b0, R_MISS},
    '{ROW_REQ, REQ_LOOK, 32'hAAAA_AAAA, 8'h00, 32'h0000_0000, 16'h0, 1'b0, R_MISS}
  };

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              req_type     = REQ_ADD;
  logic [KEY_W-1:0]  client_key   = '0;
  logic [HOST_W-1:0] host_in      = '0;
  logic [TIME_W-1:0] now_seconds  = '0;
  logic              out_ready    = 1'b0;
  logic              cfg_valid    = 1'b0;
  logic [EXP_W-1:0]  cfg_data     = '0;

  logic              in_ready;
  logic              out_valid;
  logic              found;
  logic [HOST_W-1:0] host_out;
  logic              expired;
  logic              added;
  logic              table_full;
  logic              cfg_ready;

  // Shadow copy of the session table and the aging limit.
  logic                 entry_live  [SLOTS];
  logic [KEY_W-1:0]     entry_key   [SLOTS];
  logic [HOST_BITS-1:0] entry_host  [SLOTS];
  logic [TIME_W-1:0]    entry_stamp [SLOTS];
  logic [EXP_W-1:0]     expiry_limit;

  reply_t            pending_replies [$];
  logic [KEY_W-1:0]  key_pool [KEY_POOL];
  logic [TIME_W-1:0] clock_now = '0;
  bit                quiet     = 1'b0;
  int                hold_left = 0;
  int                errors    = 0;
  int                cycle_count = 0;

  persistence_table_with_aging_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .req_type_i    (req_type),
    .client_key_i  (client_key),
    .host_in_i     (host_in),
    .now_seconds_i (now_seconds),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .found_o       (found),
    .host_out_o    (host_out),
    .expired_o     (expired),
    .added_o       (added),
    .table_full_o  (table_full),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic reply_t table_step(logic req, logic [KEY_W-1:0] key,
                                        logic [HOST_W-1:0] host, logic [TIME_W-1:0] stamp);
    reply_t            r;
    logic [TIME_W-1:0] age;
    r = '0;
    if (req == REQ_ADD) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (!entry_live[s]) begin
          entry_live[s]  = 1'b1;
          entry_key[s]   = key;
          entry_host[s]  = host[HOST_BITS-1:0];
          entry_stamp[s] = stamp;
          r.added = 1'b1;
          return r;
        end
      end
      r.full = 1'b1;
      return r;
    end
    // Only the lowest matching slot counts, stale or not.
    for (int s = 0; s < SLOTS; s++) begin
      if (entry_live[s] && entry_key[s] == key) begin
        age = stamp - entry_stamp[s];
        if (expiry_limit != 0 && age > expiry_limit) begin
          entry_live[s] = 1'b0;
          r.expired = 1'b1;
        end else begin
          r.found = 1'b1;
          r.host  = HOST_W'(entry_host[s]);
        end
        return r;
      end
    end
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(KEY_POOL - 1)];
    return $urandom();
  endfunction

  // Time mostly creeps forward, sometimes jumps past the limit, now and then
  // lands anywhere, and occasionally steps back so the age wraps.
  function automatic logic [TIME_W-1:0] next_stamp();
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) clock_now += $urandom_range(0, 3);
    else if (pick < 85) clock_now += $urandom_range(0, 2 * expiry_limit + 2);
    else if (pick < 95) clock_now += $urandom_range(0, 1 << 17);
    else if (pick < 98) clock_now = $urandom();
    else return clock_now - $urandom_range(1, 3);
    return clock_now;
  endfunction

  task automatic send_req(input logic req, input logic [KEY_W-1:0] key,
                          input logic [HOST_W-1:0] host, input logic [TIME_W-1:0] stamp,
                          input logic typed, input reply_t want);
    reply_t predicted;
    if (!quiet && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    client_key  <= key;
    host_in     <= host;
    now_seconds <= stamp;
    do @(posedge clk); while (!in_ready);
    predicted = table_step(req, key, host, stamp);
    pending_replies.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
  endtask

  task automatic set_expiry(input logic [EXP_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    expiry_limit = value;
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $error("result transfer with nothing outstanding");
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          errors++;
        end
        if (host_out !== want.host) begin
          $error("host_out: expected %0d, got %0d", want.host, host_out);
          errors++;
        end
        if (expired !== want.expired) begin
          $error("expired: expected %0d, got %0d", want.expired, expired);
          errors++;
        end
        if (added !== want.added) begin
          $error("added: expected %0d, got %0d", want.added, added);
          errors++;
        end
        if (table_full !== want.full) begin
          $error("table_full: expected %0d, got %0d", want.full, table_full);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL persistence_table_with_aging_unit");
      $finish;
    end
  end

  initial begin
    logic [EXP_W-1:0] phase_limit [PHASES];
    int               add_pct     [PHASES];
    logic             req;

    for (int s = 0; s < SLOTS; s++) begin
      entry_live[s]  = 1'b0;
      entry_key[s]   = '0;
      entry_host[s]  = '0;
      entry_stamp[s] = '0;
    end
    expiry_limit = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < KEY_POOL; k++) key_pool[k] = $urandom();

    phase_limit[0] = 16'd0;     add_pct[0] = 75;
    phase_limit[1] = 16'd1;     add_pct[1] = 35;
    phase_limit[2] = 16'hFFFF;  add_pct[2] = 50;
    phase_limit[3] = EXP_W'($urandom_range(2, 65534));  add_pct[3] = 50;
    phase_limit[4] = EXP_W'($urandom_range(1, 20));     add_pct[4] = 60;
    phase_limit[5] = EXP_W'($urandom_range(2, 65534));  add_pct[5] = 45;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        set_expiry(DIRECTED[i].limit);
      end else begin
        send_req(DIRECTED[i].req, DIRECTED[i].key, DIRECTED[i].host, DIRECTED[i].stamp,
                 DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      set_expiry(phase_limit[p]);
      quiet = (p == 2);
      // Stall the result side long enough that requests back up at the input.
      if (p == 0) hold_left = LONG_HOLD;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) wait_drained();
        req = ($urandom_range(99) < add_pct[p]) ? REQ_ADD : REQ_LOOK;
        send_req(req, pick_key(), HOST_W'($urandom_range(255)), next_stamp(), 1'b0, R_MISS);
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("PASS persistence_table_with_aging_unit");
    end else begin
      $display("FAIL persistence_table_with_aging_unit");
    end
    $finish;
  end

endmodule
